/* design/fmp_pkg.sv */
// ----------------------------------------------------------------------------
// fmp_pkg
// Types and constants shared by the Fourier modulus projection core.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int LAT        = DIV_STEPS + SQRT_STEPS;

  typedef enum logic [2:0] {
    REG_TOL    = 3'd0,
    REG_MAXP   = 3'd1,
    REG_BS_EN  = 3'd2,
    REG_CX     = 3'd3,
    REG_CY     = 3'd4,
    REG_RSQ    = 3'd5,
    REG_ROWS   = 3'd6,
    REG_COLS   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_ROOT  = 2'd1,
    MODE_SCALE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
    logic signed [31:0] est_re;
    logic signed [31:0] est_im;
    logic signed [31:0] meas_re;
    logic signed [31:0] meas_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_re;
    logic signed [31:0] new_im;
    logic               blocked;
    logic               saturated;
  } out_item_t;

  // Item context carried alongside the divider and square-root stages
  typedef struct packed {
    mode_t              mode;
    logic               blocked;
    logic               rsat;
    logic signed [31:0] est_re;
    logic signed [31:0] est_im;
    logic [63:0]        mp;
  } side_t;

endpackage

/* design/fmp_div.sv */
// ----------------------------------------------------------------------------
// fmp_div
// Pipelined restoring divider: q = floor(num * 2^32 / den), one bit per stage.
// ----------------------------------------------------------------------------
module fmp_div
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] q_o
);

  logic [63:0] rem_r [DIV_STEPS];
  logic [31:0] low_r [DIV_STEPS];
  logic [63:0] q_r   [DIV_STEPS];
  logic [63:0] den_r [DIV_STEPS];

  genvar g;
  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [63:0] rem_in, q_in, den_in, trial;
      logic [31:0] low_in;
      logic        ge;
      if (g == 0) begin : g_first
        assign rem_in = {32'd0, num_i[63:32]};
        assign low_in = num_i[31:0];
        assign q_in   = '0;
        assign den_in = den_i;
      end else begin : g_next
        assign rem_in = rem_r[g-1];
        assign low_in = low_r[g-1];
        assign q_in   = q_r[g-1];
        assign den_in = den_r[g-1];
      end
      assign trial = {rem_in[62:0], low_in[31]};
      assign ge    = trial >= den_in;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? trial - den_in : trial;
          low_r[g] <= {low_in[30:0], 1'b0};
          q_r[g]   <= {q_in[62:0], ge};
          den_r[g] <= den_in;
        end
      end
    end
  endgenerate

  assign q_o = q_r[DIV_STEPS-1];

endmodule

/* design/fmp_sqrt.sv */
// ----------------------------------------------------------------------------
// fmp_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module fmp_sqrt
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_i,
  output logic [31:0] root_o
);

  logic [63:0] v_r   [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];

  genvar g;
  generate
    for (g = 0; g < SQRT_STEPS; g++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
      logic [63:0] v_in, res_in;
      logic [64:0] trial;
      logic        ge;
      if (g == 0) begin : g_first
        assign v_in   = v_i;
        assign res_in = '0;
      end else begin : g_next
        assign v_in   = v_r[g-1];
        assign res_in = res_r[g-1];
      end
      assign trial = {1'b0, res_in} + {1'b0, BIT};
      assign ge    = {1'b0, v_in} >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[g]   <= ge ? v_in - trial[63:0] : v_in;
          res_r[g] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
        end
      end
    end
  endgenerate

  assign root_o = res_r[SQRT_STEPS-1][31:0];

endmodule

/* design/fourier_modulus_projection_core.sv */
// ----------------------------------------------------------------------------
// fourier_modulus_projection_core
// Per-pixel Fourier modulus projection with beam stop and power dead band.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one pixel item (coordinates, estimate, measured
//   sample). out_valid/out_ready carry one result item per input item, in
//   order. The user must write registers via APB (8-byte stride) only while the
//   core is idle, not enforced by the core; reads return current register values.
// Timing:
//   The pipeline length is set mainly by the one-bit-per-stage ratio divider
//   (64 stages) and the shared square-root pipeline (32 stages). Throughput
//   is one item per cycle while a waiting result with out_ready low does not hold it.
// Reset:
//   rst_n clears all valid bits and loads the register defaults.
// Stall:
//   When a result waits at the output and out_ready is low, the whole
//   pipeline holds; in_ready drops in the same cycle and nothing is lost.
// ----------------------------------------------------------------------------
module fourier_modulus_projection_core
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [62:0] tol_r, maxp_r;
  logic        bs_en_r;
  logic [11:0] cx_r, cy_r;
  logic [25:0] rsq_r;
  logic [12:0] rows_r, cols_r;
  cfg_reg_t    idx;

  assign idx    = cfg_reg_t'(paddr[5:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= '0;
      maxp_r  <= '1;
      bs_en_r <= 1'b0;
      cx_r    <= '0;
      cy_r    <= '0;
      rsq_r   <= '0;
      rows_r  <= 13'(MAX_DIM);
      cols_r  <= 13'(MAX_DIM);
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_TOL:   tol_r   <= pwdata[62:0];
        REG_MAXP:  maxp_r  <= pwdata[62:0];
        REG_BS_EN: bs_en_r <= pwdata[0];
        REG_CX:    cx_r    <= pwdata[11:0];
        REG_CY:    cy_r    <= pwdata[11:0];
        REG_RSQ:   rsq_r   <= pwdata[25:0];
        REG_ROWS:  rows_r  <= pwdata[12:0];
        REG_COLS:  cols_r  <= pwdata[12:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TOL:   prdata = {1'b0, tol_r};
      REG_MAXP:  prdata = {1'b0, maxp_r};
      REG_BS_EN: prdata = {63'd0, bs_en_r};
      REG_CX:    prdata = {52'd0, cx_r};
      REG_CY:    prdata = {52'd0, cy_r};
      REG_RSQ:   prdata = {38'd0, rsq_r};
      REG_ROWS:  prdata = {51'd0, rows_r};
      REG_COLS:  prdata = {51'd0, cols_r};
      default:   prdata = '0;
    endcase
  end

  // Advance every stage together unless a result is waiting unaccepted
  logic en;
  logic out_vld_r;
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // ---------------- P1: capture the item ----------------
  logic     v1_r;
  in_item_t p1_r;

  // ---------------- P2: squares, quadrant swap ----------------
  logic               v2_r;
  logic [63:0]        er2_r, ei2_r, mr2_r, mi2_r;
  logic signed [13:0] dx_r, dy_r;
  logic signed [31:0] e2re_r, e2im_r;

  logic [12:0] rows_c, cols_c;
  logic [11:0] half_r, half_c;
  logic [12:0] sw_x, sw_y;
  assign rows_c = (rows_r > 13'(MAX_DIM)) ? 13'(MAX_DIM) : rows_r;
  assign cols_c = (cols_r > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cols_r;
  assign half_r = rows_c[12:1];
  assign half_c = cols_c[12:1];
  assign sw_x = (p1_r.pixel_row >= half_r) ? {1'b0, p1_r.pixel_row - half_r}
                                           : {1'b0, p1_r.pixel_row} + {1'b0, half_r};
  assign sw_y = (p1_r.pixel_col >= half_c) ? {1'b0, p1_r.pixel_col - half_c}
                                           : {1'b0, p1_r.pixel_col} + {1'b0, half_c};

  // ---------------- P3: powers, squared distance ----------------
  logic               v3_r;
  logic [63:0]        sp3_r, mp3_r;
  logic [26:0]        d2_r;
  logic signed [31:0] e3re_r, e3im_r;
  logic signed [27:0] dx2, dy2;
  assign dx2 = dx_r * dx_r;
  assign dy2 = dy_r * dy_r;

  // ---------------- P4: clamp measured power, beam stop test ----------------
  logic               v4_r, blk4_r, zero4_r;
  logic [63:0]        sp4_r, mp4_r;
  logic signed [31:0] e4re_r, e4im_r;
  logic [63:0]        maxp64;
  assign maxp64 = {1'b0, maxp_r};

  // ---------------- P5: dead band sums ----------------
  logic               v5_r, blk5_r, zero5_r;
  logic [63:0]        sp5_r, mp5_r, mpm5_r;
  logic [64:0]        spt5_r, mpt5_r;
  logic signed [31:0] e5re_r, e5im_r;

  // ---------------- P6: numerator select, ratio overflow test ----------------
  logic               v6_r;
  logic [63:0]        num6_r, sp6_r;
  side_t              sb6_r;
  logic               up5, dn5;
  logic [63:0]        num5;
  assign up5  = {1'b0, mp5_r} > spt5_r;
  assign dn5  = mpt5_r < {1'b0, sp5_r};
  assign num5 = up5 ? mpm5_r : mpt5_r[63:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // P1
      p1_r <= in_data;
      // P2
      er2_r  <= 64'(p1_r.est_re * p1_r.est_re);
      ei2_r  <= 64'(p1_r.est_im * p1_r.est_im);
      mr2_r  <= 64'(p1_r.meas_re * p1_r.meas_re);
      mi2_r  <= 64'(p1_r.meas_im * p1_r.meas_im);
      dx_r   <= $signed({1'b0, sw_x}) - $signed({2'b0, cx_r});
      dy_r   <= $signed({1'b0, sw_y}) - $signed({2'b0, cy_r});
      e2re_r <= p1_r.est_re;
      e2im_r <= p1_r.est_im;
      // P3
      sp3_r  <= er2_r + ei2_r;
      mp3_r  <= mr2_r + mi2_r;
      d2_r   <= 27'(dx2) + 27'(dy2);
      e3re_r <= e2re_r;
      e3im_r <= e2im_r;
      // P4
      sp4_r   <= sp3_r;
      mp4_r   <= (mp3_r >= maxp64) ? ((sp3_r > maxp64) ? sp3_r : maxp64) : mp3_r;
      blk4_r  <= bs_en_r && (d2_r < {1'b0, rsq_r});
      zero4_r <= (sp3_r == 64'd0);
      e4re_r  <= e3re_r;
      e4im_r  <= e3im_r;
      // P5
      sp5_r   <= sp4_r;
      mp5_r   <= mp4_r;
      mpm5_r  <= mp4_r - {1'b0, tol_r};
      spt5_r  <= {1'b0, sp4_r} + {2'b0, tol_r};
      mpt5_r  <= {1'b0, mp4_r} + {2'b0, tol_r};
      blk5_r  <= blk4_r;
      zero5_r <= zero4_r;
      e5re_r  <= e4re_r;
      e5im_r  <= e4im_r;
      // P6
      num6_r         <= num5;
      sp6_r          <= sp5_r;
      sb6_r.blocked  <= blk5_r;
      sb6_r.rsat     <= (sp5_r[63:32] == 32'd0) && (num5 >= {sp5_r[31:0], 32'd0});
      sb6_r.est_re   <= e5re_r;
      sb6_r.est_im   <= e5im_r;
      sb6_r.mp       <= mp5_r;
      if (blk5_r)               sb6_r.mode <= MODE_PASS;
      else if (zero5_r)         sb6_r.mode <= MODE_ROOT;
      else if (up5 || dn5)      sb6_r.mode <= MODE_SCALE;
      else                      sb6_r.mode <= MODE_PASS;
    end
  end

  // ---------------- divider and square root ----------------
  side_t       sb_r [LAT];
  logic [LAT-1:0] vsb_r;
  logic [63:0] q;
  logic [63:0] sq_in;
  logic [31:0] root;
  side_t       sb_div;

  fmp_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num6_r),
    .den_i (sp6_r),
    .q_o   (q)
  );

  // Pick the square-root operand: measured power for a zero estimate,
  // otherwise the squared ratio, clipped on overflow
  assign sb_div = sb_r[DIV_STEPS-1];
  assign sq_in  = (sb_div.mode == MODE_ROOT) ? sb_div.mp : (sb_div.rsat ? '1 : q);

  fmp_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .v_i    (sq_in),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb6_r;
      for (int k = 1; k < LAT; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // ---------------- M1: scale products ----------------
  side_t       sbm_r;
  logic [31:0] root_m_r;
  logic [63:0] pre_r, pim_r;
  logic [31:0] mag_re, mag_im;
  side_t       sb_end;
  assign sb_end = sb_r[LAT-1];
  assign mag_re = sb_end.est_re[31] ? 32'd0 - sb_end.est_re : sb_end.est_re;
  assign mag_im = sb_end.est_im[31] ? 32'd0 - sb_end.est_im : sb_end.est_im;

  always_ff @(posedge clk) begin
    if (en) begin
      sbm_r    <= sb_end;
      root_m_r <= root;
      pre_r    <= {32'd0, mag_re} * {32'd0, root};
      pim_r    <= {32'd0, mag_im} * {32'd0, root};
    end
  end

  // ---------------- M2: shift, sign, saturate ----------------
  function automatic logic [32:0] sat_part(input logic [63:0] prod, input logic neg);
    logic [47:0] p;
    logic [32:0] r;
    p = prod[63:16];
    if (!neg && p > 48'h7FFF_FFFF)     r = {1'b1, 32'h7FFF_FFFF};
    else if (neg && p > 48'h8000_0000) r = {1'b1, 32'h8000_0000};
    else if (neg)                      r = {1'b0, 32'd0 - p[31:0]};
    else                               r = {1'b0, p[31:0]};
    return r;
  endfunction

  logic [32:0] sre, sim;
  out_item_t   res;
  assign sre = sat_part(pre_r, sbm_r.est_re[31]);
  assign sim = sat_part(pim_r, sbm_r.est_im[31]);

  always_comb begin
    res.blocked = sbm_r.blocked;
    case (sbm_r.mode)
      MODE_ROOT: begin
        res.new_re    = root_m_r[31] ? 32'h7FFF_FFFF : root_m_r;
        res.new_im    = '0;
        res.saturated = root_m_r[31];
      end
      MODE_SCALE: begin
        res.new_re    = sre[31:0];
        res.new_im    = sim[31:0];
        res.saturated = sbm_r.rsat | sre[32] | sim[32];
      end
      default: begin
        res.new_re    = sbm_r.est_re;
        res.new_im    = sbm_r.est_im;
        res.saturated = 1'b0;
      end
    endcase
  end

  out_item_t out_r;
  logic      vm_r;

  always_ff @(posedge clk) begin
    if (en) out_r <= res;
  end

  // Valid bits travel with the data through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      vsb_r     <= '0;
      vm_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r;
      vsb_r     <= {vsb_r[LAT-2:0], v6_r};
      vm_r      <= vsb_r[LAT-1];
      out_vld_r <= vm_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

/* design/fmp_checker.sv */
// ----------------------------------------------------------------------------
// fmp_checker
// Port-level checks for the Fourier modulus projection core.
// ----------------------------------------------------------------------------
module fmp_checker
  import fmp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input side advances exactly when the output slot can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output slot");

  // A blocked (beam stop) pixel never reports clipping
  a_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.blocked |-> !out_data.saturated)
    else $error("blocked item flagged saturated");

  // Drop all results on reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fourier_modulus_projection_core fmp_checker u_fmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
